// ===== rtl/core/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg: shared constants for the segment distance pipeline
// Holds the result width, the front depth of the point-to-segment unit and
// the width of the scaled squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  // Width of the distance result
  localparam int GAP_WIDTH = 25;

  // Register stages of the point-to-segment unit ahead of its divider
  localparam int UNIT_STAGES = 5;

  // Width of a squared distance scaled by 2^(2*frac)
  function automatic int quot_width(input int cw, input int frac);
    return 2 * cw + 3 + 2 * frac;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssd_unit.sv =====
// ----------------------------------------------------------------------------
// ssd_unit: squared point-to-segment distance
// Returns floor(dist^2 * 2^(2*FRAC_BITS)) for a point and a segment. It uses a
// bit-per-stage restoring divider for the perpendicular case.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_unit import ssd_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8,
  localparam int QW         = quot_width(COORD_WIDTH, FRAC_BITS)
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [COORD_WIDTH-1:0] px_i,
  input  wire logic signed [COORD_WIDTH-1:0] py_i,
  input  wire logic signed [COORD_WIDTH-1:0] x1_i,
  input  wire logic signed [COORD_WIDTH-1:0] y1_i,
  input  wire logic signed [COORD_WIDTH-1:0] x2_i,
  input  wire logic signed [COORD_WIDTH-1:0] y2_i,
  output logic             [QW-1:0]          dist2_o
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = 2 * DW + 1;
  localparam int HW  = DW;
  localparam int SQW = 4 * HW;
  localparam int NW  = SQW + 2 * FRAC_BITS;

  // Stage 1: differences
  logic signed [DW-1:0] dx_q, dy_q, vx_q, vy_q, wx_q, wy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= DW'(x2_i) - DW'(x1_i);
      dy_q <= DW'(y2_i) - DW'(y1_i);
      vx_q <= DW'(px_i) - DW'(x1_i);
      vy_q <= DW'(py_i) - DW'(y1_i);
      wx_q <= DW'(px_i) - DW'(x2_i);
      wy_q <= DW'(py_i) - DW'(y2_i);
    end
  end

  // Stage 2: products
  logic signed [PW-1:0] dxvx_q, dyvy_q, dxwx_q, dywy_q, dxvy_q, dyvx_q;
  logic signed [PW-1:0] dxdx_q, dydy_q, vxvx_q, vyvy_q, wxwx_q, wywy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxvx_q <= dx_q * vx_q;
      dyvy_q <= dy_q * vy_q;
      dxwx_q <= dx_q * wx_q;
      dywy_q <= dy_q * wy_q;
      dxvy_q <= dx_q * vy_q;
      dyvx_q <= dy_q * vx_q;
      dxdx_q <= dx_q * dx_q;
      dydy_q <= dy_q * dy_q;
      vxvx_q <= vx_q * vx_q;
      vyvy_q <= vy_q * vy_q;
      wxwx_q <= wx_q * wx_q;
      wywy_q <= wy_q * wy_q;
    end
  end

  // Stage 3: dot products, cross product and squared lengths
  logic signed [SW-1:0] dotv_q, dotw_q, cross_q;
  logic        [PW-1:0] len2_q, dv2_q, dw2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dotv_q  <= SW'(dxvx_q) + SW'(dyvy_q);
      dotw_q  <= -(SW'(dxwx_q) + SW'(dywy_q));
      cross_q <= SW'(dxvy_q) - SW'(dyvx_q);
      len2_q  <= PW'(dxdx_q) + PW'(dydy_q);
      dv2_q   <= PW'(vxvx_q) + PW'(vyvy_q);
      dw2_q   <= PW'(wxwx_q) + PW'(wywy_q);
    end
  end

  // Stage 4: pick the case, split |cross| for the square
  logic          perp_d;
  logic [PW-1:0] pd2_d;
  logic [SW-1:0] cabs_w;
  logic [PW-1:0] cmag_w;

  always_comb begin
    perp_d = 1'b0;
    pd2_d  = dv2_q;
    if (dotv_q < 0) begin
      pd2_d = dv2_q;
    end else if (dotw_q < 0) begin
      pd2_d = dw2_q;
    end else if (len2_q == '0) begin
      pd2_d = dv2_q;
    end else begin
      perp_d = 1'b1;
    end
    cabs_w = (cross_q < 0) ? SW'(-cross_q) : SW'(cross_q);
    cmag_w = cabs_w[PW-1:0];
  end

  logic            perp4_q;
  logic [PW-1:0]   pd24_q, len24_q;
  logic [2*HW-1:0] hh_q, hl_q, ll_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      perp4_q <= perp_d;
      pd24_q  <= pd2_d;
      len24_q <= len2_q;
      hh_q    <= cmag_w[2*HW-1:HW] * cmag_w[2*HW-1:HW];
      hl_q    <= cmag_w[2*HW-1:HW] * cmag_w[HW-1:0];
      ll_q    <= cmag_w[HW-1:0] * cmag_w[HW-1:0];
    end
  end

  // Stage 5: numerator and denominator, start of division
  logic [SQW-1:0] c2_w, num_w;
  logic [NW-1:0]  numer_w;

  always_comb begin
    c2_w    = (SQW'(hh_q) << (2 * HW)) + (SQW'(hl_q) << (HW + 1)) + SQW'(ll_q);
    num_w   = perp4_q ? c2_w : SQW'(pd24_q);
    numer_w = NW'(num_w) << (2 * FRAC_BITS);
  end

  logic [PW-1:0] rem_q [0:QW];
  logic [PW-1:0] den_q [0:QW];
  logic [QW-1:0] rq_q  [0:QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= PW'(numer_w >> QW);
      den_q[0] <= perp4_q ? len24_q : PW'(1);
      rq_q[0]  <= numer_w[QW-1:0];
    end
  end

  // Divider: one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [PW:0] trial_w, diff_w;
    logic        ge_w;

    always_comb begin
      trial_w = {rem_q[k-1], rq_q[k-1][QW-1]};
      ge_w    = trial_w >= {1'b0, den_q[k-1]};
      diff_w  = ge_w ? (trial_w - {1'b0, den_q[k-1]}) : trial_w;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= diff_w[PW-1:0];
        den_q[k] <= den_q[k-1];
        rq_q[k]  <= {rq_q[k-1][QW-2:0], ge_w};
      end
    end
  end

  assign dist2_o = rq_q[QW];

endmodule

`default_nettype wire

// ===== rtl/core/segment_segment_distance.sv =====
// ----------------------------------------------------------------------------
// segment_segment_distance: distance between two 2D segments
// Input channel: eight signed endpoint coordinates with in_valid_i and
// in_stall_o. Output channel: gap_length_o (unsigned, FRAC_BITS fraction
// bits, truncated) and touching_o with out_valid_o and out_stall_i.
// An item is taken on each edge where valid is high and stall is low.
// One item enters per cycle while the pipeline is not frozen by a stall. Here
// QW = 2*COORD_WIDTH + 3 + 2*FRAC_BITS is the quotient width and RW = (QW + 1) / 2.
// The depth comes from the bit-per-stage divider in each of the four
// point-to-segment units and from the bit-per-stage square root.
// Intersecting segments give touching_o = 1 and a zero distance.
// Reset clears the valid bits only, so the pipeline comes up empty.
// While the output holds an item and out_stall_i is high, the whole pipeline
// freezes and in_stall_o is raised, so no item is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_segment_distance import ssd_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] seg_a_x1_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_a_y1_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_a_x2_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_a_y2_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_b_x1_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_b_y1_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_b_x2_i,
  input  wire logic signed [COORD_WIDTH-1:0] seg_b_y2_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic             [GAP_WIDTH-1:0]   gap_length_o,
  output logic                               touching_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = 2 * DW + 1;
  localparam int QW  = quot_width(COORD_WIDTH, FRAC_BITS);
  localparam int RW  = (QW + 1) / 2;
  localparam int U   = UNIT_STAGES + QW;
  localparam int LAT = U + RW + 3;

  // Global advance: freeze only when a finished item waits on a stall
  logic en_w;
  logic valid_q [1:LAT];

  assign en_w       = !(valid_q[LAT] && out_stall_i);
  assign in_stall_o = !en_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= LAT; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (en_w) begin
      valid_q[1] <= in_valid_i;
      for (int i = 2; i <= LAT; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // Four point-to-segment units
  logic [QW-1:0] d2_w [0:3];

  ssd_unit #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_a1 (
    .clk_i, .en_i(en_w), .px_i(seg_a_x1_i), .py_i(seg_a_y1_i),
    .x1_i(seg_b_x1_i), .y1_i(seg_b_y1_i), .x2_i(seg_b_x2_i), .y2_i(seg_b_y2_i),
    .dist2_o(d2_w[0])
  );
  ssd_unit #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_a2 (
    .clk_i, .en_i(en_w), .px_i(seg_a_x2_i), .py_i(seg_a_y2_i),
    .x1_i(seg_b_x1_i), .y1_i(seg_b_y1_i), .x2_i(seg_b_x2_i), .y2_i(seg_b_y2_i),
    .dist2_o(d2_w[1])
  );
  ssd_unit #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_b1 (
    .clk_i, .en_i(en_w), .px_i(seg_b_x1_i), .py_i(seg_b_y1_i),
    .x1_i(seg_a_x1_i), .y1_i(seg_a_y1_i), .x2_i(seg_a_x2_i), .y2_i(seg_a_y2_i),
    .dist2_o(d2_w[2])
  );
  ssd_unit #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_b2 (
    .clk_i, .en_i(en_w), .px_i(seg_b_x2_i), .py_i(seg_b_y2_i),
    .x1_i(seg_a_x1_i), .y1_i(seg_a_y1_i), .x2_i(seg_a_x2_i), .y2_i(seg_a_y2_i),
    .dist2_o(d2_w[3])
  );

  // Intersection test, stage 1: coordinates and differences
  logic signed [CW-1:0] c1_q [0:7];
  logic signed [CW-1:0] c2_q [0:7];
  logic signed [DW-1:0] ebx_q, eby_q, eax_q, eay_q;
  logic signed [DW-1:0] ra1x_q, ra1y_q, ra2x_q, ra2y_q;
  logic signed [DW-1:0] rb1x_q, rb1y_q, rb2x_q, rb2y_q;

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      c1_q[0] <= seg_a_x1_i;
      c1_q[1] <= seg_a_y1_i;
      c1_q[2] <= seg_a_x2_i;
      c1_q[3] <= seg_a_y2_i;
      c1_q[4] <= seg_b_x1_i;
      c1_q[5] <= seg_b_y1_i;
      c1_q[6] <= seg_b_x2_i;
      c1_q[7] <= seg_b_y2_i;
      ebx_q   <= DW'(seg_b_x2_i) - DW'(seg_b_x1_i);
      eby_q   <= DW'(seg_b_y2_i) - DW'(seg_b_y1_i);
      ra1x_q  <= DW'(seg_a_x1_i) - DW'(seg_b_x1_i);
      ra1y_q  <= DW'(seg_a_y1_i) - DW'(seg_b_y1_i);
      ra2x_q  <= DW'(seg_a_x2_i) - DW'(seg_b_x1_i);
      ra2y_q  <= DW'(seg_a_y2_i) - DW'(seg_b_y1_i);
      eax_q   <= DW'(seg_a_x2_i) - DW'(seg_a_x1_i);
      eay_q   <= DW'(seg_a_y2_i) - DW'(seg_a_y1_i);
      rb1x_q  <= DW'(seg_b_x1_i) - DW'(seg_a_x1_i);
      rb1y_q  <= DW'(seg_b_y1_i) - DW'(seg_a_y1_i);
      rb2x_q  <= DW'(seg_b_x2_i) - DW'(seg_a_x1_i);
      rb2y_q  <= DW'(seg_b_y2_i) - DW'(seg_a_y1_i);
    end
  end

  // Stage 2: orientation products
  logic signed [PW-1:0] o1p_q, o1n_q, o2p_q, o2n_q, o3p_q, o3n_q, o4p_q, o4n_q;

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      c2_q  <= c1_q;
      o1p_q <= ebx_q * ra1y_q;
      o1n_q <= eby_q * ra1x_q;
      o2p_q <= ebx_q * ra2y_q;
      o2n_q <= eby_q * ra2x_q;
      o3p_q <= eax_q * rb1y_q;
      o3n_q <= eay_q * rb1x_q;
      o4p_q <= eax_q * rb2y_q;
      o4n_q <= eay_q * rb2x_q;
    end
  end

  // Stage 3: signs, bounding boxes, meet decision
  logic signed [SW-1:0] o_w [1:4];
  logic                 pos_w [1:4];
  logic                 neg_w [1:4];
  logic                 box_w [1:4];
  logic                 meet_d;

  function automatic logic in_box(input logic signed [CW-1:0] ax, ay, bx, by, qx, qy);
    return (qx >= ax || qx >= bx) && (qx <= ax || qx <= bx) &&
           (qy >= ay || qy >= by) && (qy <= ay || qy <= by);
  endfunction

  always_comb begin
    o_w[1] = SW'(o1p_q) - SW'(o1n_q);
    o_w[2] = SW'(o2p_q) - SW'(o2n_q);
    o_w[3] = SW'(o3p_q) - SW'(o3n_q);
    o_w[4] = SW'(o4p_q) - SW'(o4n_q);
    for (int i = 1; i <= 4; i++) begin
      pos_w[i] = o_w[i] > 0;
      neg_w[i] = o_w[i] < 0;
    end
    box_w[1] = in_box(c2_q[4], c2_q[5], c2_q[6], c2_q[7], c2_q[0], c2_q[1]);
    box_w[2] = in_box(c2_q[4], c2_q[5], c2_q[6], c2_q[7], c2_q[2], c2_q[3]);
    box_w[3] = in_box(c2_q[0], c2_q[1], c2_q[2], c2_q[3], c2_q[4], c2_q[5]);
    box_w[4] = in_box(c2_q[0], c2_q[1], c2_q[2], c2_q[3], c2_q[6], c2_q[7]);
    meet_d = (((pos_w[1] && neg_w[2]) || (neg_w[1] && pos_w[2])) &&
              ((pos_w[3] && neg_w[4]) || (neg_w[3] && pos_w[4])));
    for (int i = 1; i <= 4; i++) begin
      if (!pos_w[i] && !neg_w[i] && box_w[i]) begin
        meet_d = 1'b1;
      end
    end
  end

  // Carry the meet flag alongside the distance path
  logic meet_q [3:LAT-1];

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      meet_q[3] <= meet_d;
      for (int i = 4; i <= LAT - 1; i++) begin
        meet_q[i] <= meet_q[i-1];
      end
    end
  end

  // Minimum of the four squared distances over two stages
  logic [QW-1:0]   min01_q, min23_q;
  logic [2*RW-1:0] sx_q  [0:RW];
  logic [RW:0]     srem_q [0:RW];
  logic [RW-1:0]   sroot_q [0:RW];

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      min01_q    <= (d2_w[1] < d2_w[0]) ? d2_w[1] : d2_w[0];
      min23_q    <= (d2_w[3] < d2_w[2]) ? d2_w[3] : d2_w[2];
      sx_q[0]    <= (2*RW)'((min23_q < min01_q) ? min23_q : min01_q);
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
    end
  end

  // Square root: one result bit per stage
  for (genvar k = 1; k <= RW; k++) begin : g_sqrt
    logic [RW+2:0] cur_w, trial_w;
    logic          ge_w;

    always_comb begin
      cur_w   = {srem_q[k-1], sx_q[k-1][2*RW-2*k+1 -: 2]};
      trial_w = (RW+3)'({sroot_q[k-1], 2'b01});
      ge_w    = cur_w >= trial_w;
    end

    always_ff @(posedge clk_i) begin
      if (en_w) begin
        sx_q[k]    <= sx_q[k-1];
        srem_q[k]  <= ge_w ? (RW+1)'(cur_w - trial_w) : (RW+1)'(cur_w);
        sroot_q[k] <= {sroot_q[k-1][RW-2:0], ge_w};
      end
    end
  end

  // Output register
  logic [RW+GAP_WIDTH-1:0] root_ext_w;
  logic [GAP_WIDTH-1:0]    gap_q;
  logic                    touch_q;

  assign root_ext_w = {{GAP_WIDTH{1'b0}}, sroot_q[RW]};

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      gap_q   <= meet_q[LAT-1] ? '0 : root_ext_w[GAP_WIDTH-1:0];
      touch_q <= meet_q[LAT-1];
    end
  end

  assign out_valid_o  = valid_q[LAT];
  assign gap_length_o = gap_q;
  assign touching_o   = touch_q;

endmodule

`default_nettype wire

// ===== tb/tb_segment_segment_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_segment_distance: self-checking bench for the segment distance
// Feeds pairs of segments through the valid/stall input channel. Each item
// taken is scored against a built-in predictor, and each result item is
// compared with the oldest expected result. Idle bursts fall on both sides
// except near the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_segment_distance import ssd_pkg::*;;

  localparam int CW       = 16;
  localparam int FRAC     = 8;
  localparam int QW       = quot_width(CW, FRAC);
  localparam int LATENCY  = UNIT_STAGES + QW + (QW + 1) / 2 + 3;
  localparam int N_RANDOM = 1030;
  localparam int QUIET_AT = 150;

  typedef struct {
    logic signed [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  } seg_pair_t;

  typedef struct {
    logic [GAP_WIDTH-1:0] gap;
    logic                 touching;
  } gap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] ax1 = '0, ay1 = '0, ax2 = '0, ay2 = '0;
  logic signed [CW-1:0] bx1 = '0, by1 = '0, bx2 = '0, by2 = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic [GAP_WIDTH-1:0] gap_length_o;
  logic touching_o;

  seg_pair_t   pending_pairs[$];
  gap_result_t expected_gaps[$];
  seg_pair_t   cur_pair;
  int          hold_left  = 0;
  int          stall_left = 0;
  int          mismatches = 0;
  bit          quiet      = 1'b0;

  segment_segment_distance #(
    .COORD_WIDTH(CW),
    .FRAC_BITS  (FRAC)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .seg_a_x1_i  (ax1),
    .seg_a_y1_i  (ay1),
    .seg_a_x2_i  (ax2),
    .seg_a_y2_i  (ay2),
    .seg_b_x1_i  (bx1),
    .seg_b_y1_i  (by1),
    .seg_b_x2_i  (bx2),
    .seg_b_y2_i  (by2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .gap_length_o(gap_length_o),
    .touching_o  (touching_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Integer square root, floor
  function automatic logic [63:0] isqrt_floor(input logic [127:0] v);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = {64'd0, r | (64'd1 << b)};
      if (t * t <= v) r = t[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] point_dist(input longint dx, input longint dy);
    logic [127:0] d2;
    d2 = 128'(dx * dx + dy * dy);
    return isqrt_floor(d2 << (2 * FRAC));
  endfunction

  // Distance from point p to segment (x1,y1)-(x2,y2), scaled and truncated
  function automatic logic [63:0] point_seg_dist(input longint px, py, x1, y1, x2, y2);
    longint       dx, dy, vx, vy, wx, wy, c;
    logic [127:0] len2, num;
    dx = x2 - x1; dy = y2 - y1;
    vx = px - x1; vy = py - y1;
    wx = px - x2; wy = py - y2;
    if (dx * vx + dy * vy < 0) return point_dist(vx, vy);
    if ((-dx) * wx + (-dy) * wy < 0) return point_dist(wx, wy);
    len2 = 128'(dx * dx + dy * dy);
    if (len2 == 0) return point_dist(vx, vy);
    c = dx * vy - dy * vx;
    if (c < 0) c = -c;
    num = (128'(c) * 128'(c)) << (2 * FRAC);
    return isqrt_floor(num / len2);
  endfunction

  function automatic int turn_sign(input longint ax, ay, bx, by, cx, cy);
    longint c;
    c = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    return (c > 0) - (c < 0);
  endfunction

  function automatic bit on_box(input longint ax, ay, bx, by, px, py);
    return px >= ((ax < bx) ? ax : bx) && px <= ((ax < bx) ? bx : ax) &&
           py >= ((ay < by) ? ay : by) && py <= ((ay < by) ? by : ay);
  endfunction

  function automatic gap_result_t predict_gap(input seg_pair_t s);
    longint      a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
    int          d1, d2, d3, d4;
    logic [63:0] g, best;
    gap_result_t r;
    a1x = s.ax1; a1y = s.ay1; a2x = s.ax2; a2y = s.ay2;
    b1x = s.bx1; b1y = s.by1; b2x = s.bx2; b2y = s.by2;
    d1 = turn_sign(b1x, b1y, b2x, b2y, a1x, a1y);
    d2 = turn_sign(b1x, b1y, b2x, b2y, a2x, a2y);
    d3 = turn_sign(a1x, a1y, a2x, a2y, b1x, b1y);
    d4 = turn_sign(a1x, a1y, a2x, a2y, b2x, b2y);
    r.touching = (d1 * d2 < 0 && d3 * d4 < 0)
        || (d1 == 0 && on_box(b1x, b1y, b2x, b2y, a1x, a1y))
        || (d2 == 0 && on_box(b1x, b1y, b2x, b2y, a2x, a2y))
        || (d3 == 0 && on_box(a1x, a1y, a2x, a2y, b1x, b1y))
        || (d4 == 0 && on_box(a1x, a1y, a2x, a2y, b2x, b2y));
    best = '0;
    if (!r.touching) begin
      best = point_seg_dist(a1x, a1y, b1x, b1y, b2x, b2y);
      g = point_seg_dist(a2x, a2y, b1x, b1y, b2x, b2y);
      if (g < best) best = g;
      g = point_seg_dist(b1x, b1y, a1x, a1y, a2x, a2y);
      if (g < best) best = g;
      g = point_seg_dist(b2x, b2y, a1x, a1y, a2x, a2y);
      if (g < best) best = g;
    end
    r.gap = best[GAP_WIDTH-1:0];
    return r;
  endfunction

  function automatic seg_pair_t mk_pair(input int a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y);
    seg_pair_t s;
    s.ax1 = CW'(a1x); s.ay1 = CW'(a1y); s.ax2 = CW'(a2x); s.ay2 = CW'(a2y);
    s.bx1 = CW'(b1x); s.by1 = CW'(b1y); s.bx2 = CW'(b2x); s.by2 = CW'(b2y);
    return s;
  endfunction

  function automatic int rnd_in(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int rnd_extreme();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return rnd_in(-32768, -32700);
      default: return rnd_in(32700, 32767);
    endcase
  endfunction

  // Random pair: mostly shaped near-miss and contact cases, some noise
  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    int c, ox, oy, dx, dy, t1, t2;
    s = mk_pair($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    ox = rnd_in(-32000, 32000);
    oy = rnd_in(-32000, 32000);
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4: begin
        c = rnd_in(2, 300);
        s = mk_pair(ox + rnd_in(-c, c), oy + rnd_in(-c, c), ox + rnd_in(-c, c),
                    oy + rnd_in(-c, c), ox + rnd_in(-c, c), oy + rnd_in(-c, c),
                    ox + rnd_in(-c, c), oy + rnd_in(-c, c));
      end
      5: begin
        // share one line through the origin of the box
        dx = rnd_in(-20, 20); dy = rnd_in(-20, 20);
        t1 = rnd_in(-30, 30); t2 = rnd_in(-30, 30);
        s = mk_pair(ox + t1 * dx, oy + t1 * dy, ox + t2 * dx, oy + t2 * dy,
                    ox + rnd_in(-30, 30) * dx, oy + rnd_in(-30, 30) * dy,
                    ox + rnd_in(-30, 30) * dx, oy + rnd_in(-30, 30) * dy);
      end
      6: begin
        // one or both segments collapsed to a point
        s.ax2 = s.ax1; s.ay2 = s.ay1;
        if ($urandom_range(0, 1)) begin
          s.bx2 = s.bx1; s.by2 = s.by1;
        end
        if ($urandom_range(0, 2) == 0) begin
          s.bx1 = s.ax1; s.by1 = s.ay1;
        end
      end
      7: begin
        // endpoint shared or nudged off by one
        s.bx1 = s.ax2 + CW'(rnd_in(-1, 1));
        s.by1 = s.ay2 + CW'(rnd_in(-1, 1));
      end
      8: begin
        // second segment ends a small offset from the first's far end
        dx = rnd_in(-500, 500); dy = rnd_in(-500, 500);
        c = rnd_in(-3, 3);
        s = mk_pair(ox, oy, ox + dx, oy + dy, ox + c + rnd_in(-600, 600),
                    oy - c, ox + c + dx, oy - c + dy);
      end
      default: begin
        s = mk_pair(rnd_extreme(), rnd_extreme(), rnd_extreme(), rnd_extreme(),
                    rnd_extreme(), rnd_extreme(), rnd_extreme(), rnd_extreme());
      end
    endcase
    return s;
  endfunction

  // Fill the item queue: directed corners first, then random pairs
  initial begin
    pending_pairs.push_back(mk_pair(0, 0, 10, 10, 0, 10, 10, 0));
    pending_pairs.push_back(mk_pair(0, 0, 10, 0, 10, 0, 20, 5));
    pending_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 0, 20, 0));
    pending_pairs.push_back(mk_pair(0, 0, 10, 0, 11, 0, 20, 0));
    pending_pairs.push_back(mk_pair(0, 0, 10, 0, 0, 3, 10, 3));
    pending_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 1, 5, 9));
    pending_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 0, 5, 9));
    pending_pairs.push_back(mk_pair(3, 4, 3, 4, 0, 0, 0, 0));
    pending_pairs.push_back(mk_pair(3, 4, 3, 4, 3, 4, 3, 4));
    pending_pairs.push_back(mk_pair(1, 1, 1, 1, 0, 0, 4, 0));
    pending_pairs.push_back(mk_pair(2, 0, 2, 0, 0, 0, 4, 0));
    pending_pairs.push_back(mk_pair(0, 0, 4, 0, 7, 3, 7, 3));
    pending_pairs.push_back(mk_pair(-32768, -32768, -32768, -32768,
                                    32767, 32767, 32767, 32767));
    pending_pairs.push_back(mk_pair(-32768, -32768, -32768, 32767,
                                    32767, -32768, 32767, 32767));
    pending_pairs.push_back(mk_pair(-32768, 32767, 32767, -32768,
                                    -32768, -32768, 32767, 32767));
    pending_pairs.push_back(mk_pair(-32768, -32768, 32767, -32767,
                                    32767, 32767, -32768, 32766));
    pending_pairs.push_back(mk_pair(-1, -1, -1, -1, 0, 0, 0, 0));
    pending_pairs.push_back(mk_pair(0, 0, 1, 2, 3, 1, 100, 7));
    pending_pairs.push_back(mk_pair(-5, -5, 5, 5, -5, 5, 5, -5));
    pending_pairs.push_back(mk_pair(0, 0, 32767, 1, -32768, 2, 0, 5));
    for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(random_pair());
  end

  // Input driver: hold the item while stalled, insert idle bursts between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) expected_gaps.push_back(predict_gap(cur_pair));
      if (pending_pairs.size() < QUIET_AT) quiet = 1'b1;
      if (!in_valid || !in_stall_o) begin
        if (hold_left > 0) begin
          hold_left--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          hold_left = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          cur_pair = pending_pairs.pop_front();
          ax1 <= cur_pair.ax1; ay1 <= cur_pair.ay1;
          ax2 <= cur_pair.ax2; ay2 <= cur_pair.ay2;
          bx1 <= cur_pair.bx1; by1 <= cur_pair.by1;
          bx2 <= cur_pair.bx2; by2 <= cur_pair.by2;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall: random bursts, no new ones once the run goes quiet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor: score each item taken against the oldest expectation
  always @(posedge clk_i) begin
    gap_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_gaps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: gap=%0d touching=%0b", gap_length_o, touching_o);
      end else begin
        exp_r = expected_gaps.pop_front();
        if (gap_length_o !== exp_r.gap || touching_o !== exp_r.touching) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: gap exp=%0d got=%0d, touching exp=%0b got=%0b",
                     exp_r.gap, gap_length_o, exp_r.touching, touching_o);
        end
      end
    end
  end

  // Reset, drain, verdict
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_pairs.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_gaps.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (expected_gaps.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("segment_segment_distance test passed");
    end else begin
      $display("segment_segment_distance test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("segment_segment_distance test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/ssd_pkg.sv
rtl/core/ssd_unit.sv
rtl/core/segment_segment_distance.sv
tb/tb_segment_segment_distance.sv
